/* sv/plob_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package plob_pkg;

   localparam int LEVELS      = 64;
   localparam int TOP_LEVELS  = 5;
   localparam int PRICE_BITS  = 20;
   localparam int QTY_BITS    = 24;
   localparam int RANK_BITS   = 3;
   localparam int DEPTH_BITS  = 3;
   localparam int ACTION_BITS = 2;
   localparam int IDX_BITS    = $clog2(LEVELS);
   localparam int CNT_BITS    = $clog2(LEVELS + 1);
   localparam int ENTRY_BITS  = PRICE_BITS + QTY_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = DEPTH_BITS'(TOP_LEVELS);

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [ACTION_BITS-1:0] ACT_NEW    = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_CANCEL = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_TRADE  = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      OP_NEW,
      OP_CANCEL,
      OP_TRADE,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_RANK,
      ST_EMIT
   } eng_state_type;

   typedef struct packed {
      logic                  side;
      op_type                op;
      logic [PRICE_BITS-1:0] price;
      logic [QTY_BITS-1:0]   qty;
   } cmd_type;

   typedef struct packed {
      logic                  status;
      logic                  report_side;
      logic [RANK_BITS-1:0]  rank;
      logic                  level_valid;
      logic [PRICE_BITS-1:0] level_price;
      logic [QTY_BITS-1:0]   level_quantity;
      logic [PRICE_BITS-1:0] last_trade_price;
      logic [QTY_BITS-1:0]   last_trade_quantity;
      logic                  last_item;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/plob_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module plob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* sv/plob_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module plob_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_side,
   input  logic [plob_pkg::ACTION_BITS-1:0] req_action,
   input  logic [plob_pkg::PRICE_BITS-1:0] req_price,
   input  logic [plob_pkg::QTY_BITS-1:0]   req_quantity,
   output logic                            cmd_valid,
   output plob_pkg::cmd_type               cmd,
   input  logic                            cmd_pop
);
   import plob_pkg::*;

   cmd_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   cmd_type              enq;
   logic                 push, pop;

   always_comb begin
      enq.side  = req_side;
      enq.price = req_price;
      enq.qty   = req_quantity;
      unique case (req_action)
         ACT_NEW:    enq.op = OP_NEW;
         ACT_CANCEL: enq.op = OP_CANCEL;
         ACT_TRADE:  enq.op = OP_TRADE;
         default:    enq.op = OP_NONE;
      endcase
   end

   assign req_full  = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= enq;
      end
   end
endmodule
`default_nettype wire

/* sv/plob_rsp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module plob_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  plob_pkg::rsp_type din,
   output logic              full,
   output logic              empty,
   output plob_pkg::rsp_type dout,
   input  logic              pop
);
   import plob_pkg::*;

   rsp_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full    = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign dout    = q_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= din;
      end
   end
endmodule
`default_nettype wire

/* sv/plob_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
module plob_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  plob_pkg::cmd_type               cmd,
   output logic                            cmd_pop,
   input  logic [plob_pkg::DEPTH_BITS-1:0] depth,
   output logic                            rsp_push,
   output plob_pkg::rsp_type               rsp,
   input  logic                            rsp_full
);
   import plob_pkg::*;

   eng_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [IDX_BITS-1:0]   eidx_ff, eidx_in;
   logic                  av_ff, av_in, bv_ff, bv_in;
   cmd_type               cmd_ff, cmd_in;
   logic                  match_ff, match_in;
   logic [IDX_BITS-1:0]   midx_ff, midx_in;
   logic [QTY_BITS-1:0]   mqty_ff, mqty_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   fidx_ff, fidx_in;
   logic                  status_ff, status_in;
   logic [PRICE_BITS-1:0] trp_ff, trp_in;
   logic [QTY_BITS-1:0]   trq_ff, trq_in;
   logic [LEVELS-1:0]     ask_v_ff, ask_v_in, bid_v_ff, bid_v_in;
   logic [RANK_BITS-1:0]  r_ff, r_in;
   logic                  eside_ff, eside_in;

   logic [PRICE_BITS-1:0] ap_ff [TOP_LEVELS], ap_in [TOP_LEVELS];
   logic [QTY_BITS-1:0]   aq_ff [TOP_LEVELS], aq_in [TOP_LEVELS];
   logic [TOP_LEVELS-1:0] al_ff, al_in, a_bt;
   logic [PRICE_BITS-1:0] bp_ff [TOP_LEVELS], bp_in [TOP_LEVELS];
   logic [QTY_BITS-1:0]   bq_ff [TOP_LEVELS], bq_in [TOP_LEVELS];
   logic [TOP_LEVELS-1:0] bl_ff, bl_in, b_bt;

   logic [IDX_BITS-1:0]   rd_idx, wr_idx;
   logic                  ask_wr_en, bid_wr_en;
   logic [ENTRY_BITS-1:0] wr_data, ask_rd, bid_rd;
   logic [PRICE_BITS-1:0] ask_rd_p, bid_rd_p, s_p;
   logic [QTY_BITS-1:0]   ask_rd_q, bid_rd_q, s_q;
   logic                  s_v, a_ins, b_ins;
   logic [QTY_BITS:0]     sum;
   logic [RANK_BITS-1:0]  last_rank;

   assign rd_idx   = cnt_ff[IDX_BITS-1:0];
   assign ask_rd_p = ask_rd[ENTRY_BITS-1:QTY_BITS];
   assign ask_rd_q = ask_rd[QTY_BITS-1:0];
   assign bid_rd_p = bid_rd[ENTRY_BITS-1:QTY_BITS];
   assign bid_rd_q = bid_rd[QTY_BITS-1:0];
   assign s_p      = (cmd_ff.side == SIDE_ASK) ? ask_rd_p : bid_rd_p;
   assign s_q      = (cmd_ff.side == SIDE_ASK) ? ask_rd_q : bid_rd_q;
   assign s_v      = (cmd_ff.side == SIDE_ASK) ? av_ff : bv_ff;
   assign sum      = {1'b0, mqty_ff} + {1'b0, cmd_ff.qty};

   plob_ram #(.WIDTH(ENTRY_BITS), .DEPTH(LEVELS)) u_ask_ram (
      .clock   (clock),
      .wr_en   (ask_wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_addr (rd_idx),
      .rd_data (ask_rd)
   );

   plob_ram #(.WIDTH(ENTRY_BITS), .DEPTH(LEVELS)) u_bid_ram (
      .clock   (clock),
      .wr_en   (bid_wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_addr (rd_idx),
      .rd_data (bid_rd)
   );

   always_comb begin
      if (depth == '0) begin
         last_rank = '0;
      end else if (depth > DEPTH_BITS'(TOP_LEVELS)) begin
         last_rank = RANK_BITS'(TOP_LEVELS - 1);
      end else begin
         last_rank = RANK_BITS'(depth - 1'b1);
      end
   end

   // sorted insertion into the best-level lists, one stored entry per cycle
   always_comb begin
      a_ins = (state_ff == ST_RANK) && pend_ff && av_ff;
      b_ins = (state_ff == ST_RANK) && pend_ff && bv_ff;
      for (int k = 0; k < TOP_LEVELS; k++) begin
         a_bt[k] = al_ff[k] && (ap_ff[k] < ask_rd_p);
         b_bt[k] = bl_ff[k] && (bp_ff[k] > bid_rd_p);
         ap_in[k] = ap_ff[k];
         aq_in[k] = aq_ff[k];
         bp_in[k] = bp_ff[k];
         bq_in[k] = bq_ff[k];
      end
      al_in = al_ff;
      bl_in = bl_ff;
      if (state_ff == ST_IDLE || state_ff == ST_APPLY) begin
         al_in = '0;
         bl_in = '0;
      end else begin
         if (a_ins && !a_bt[0]) begin
            ap_in[0] = ask_rd_p;
            aq_in[0] = ask_rd_q;
            al_in[0] = 1'b1;
         end
         if (b_ins && !b_bt[0]) begin
            bp_in[0] = bid_rd_p;
            bq_in[0] = bid_rd_q;
            bl_in[0] = 1'b1;
         end
         for (int k = 1; k < TOP_LEVELS; k++) begin
            if (a_ins && !a_bt[k]) begin
               if (a_bt[k-1]) begin
                  ap_in[k] = ask_rd_p;
                  aq_in[k] = ask_rd_q;
                  al_in[k] = 1'b1;
               end else begin
                  ap_in[k] = ap_ff[k-1];
                  aq_in[k] = aq_ff[k-1];
                  al_in[k] = al_ff[k-1];
               end
            end
            if (b_ins && !b_bt[k]) begin
               if (b_bt[k-1]) begin
                  bp_in[k] = bid_rd_p;
                  bq_in[k] = bid_rd_q;
                  bl_in[k] = 1'b1;
               end else begin
                  bp_in[k] = bp_ff[k-1];
                  bq_in[k] = bq_ff[k-1];
                  bl_in[k] = bl_ff[k-1];
               end
            end
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      eidx_in   = eidx_ff;
      av_in     = av_ff;
      bv_in     = bv_ff;
      cmd_in    = cmd_ff;
      match_in  = match_ff;
      midx_in   = midx_ff;
      mqty_in   = mqty_ff;
      free_in   = free_ff;
      fidx_in   = fidx_ff;
      status_in = status_ff;
      trp_in    = trp_ff;
      trq_in    = trq_ff;
      ask_v_in  = ask_v_ff;
      bid_v_in  = bid_v_ff;
      r_in      = r_ff;
      eside_in  = eside_ff;
      cmd_pop   = 1'b0;
      ask_wr_en = 1'b0;
      bid_wr_en = 1'b0;
      wr_idx    = midx_ff;
      wr_data   = {cmd_ff.price, cmd_ff.qty};
      rsp_push  = 1'b0;

      // match check on the entry read in the previous cycle
      if (state_ff == ST_SCAN && pend_ff && s_v && !match_ff && s_p == cmd_ff.price) begin
         match_in = 1'b1;
         midx_in  = eidx_ff;
         mqty_in  = s_q;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               status_in = STATUS_OK;
               match_in  = 1'b0;
               free_in   = 1'b0;
               cnt_in    = '0;
               if (cmd.op == OP_TRADE) begin
                  trp_in = cmd.price;
                  trq_in = cmd.qty;
               end
               state_in = (cmd.op == OP_NONE) ? ST_RANK : ST_SCAN;
            end
         end
         ST_SCAN, ST_RANK: begin
            if (cnt_ff < CNT_BITS'(LEVELS)) begin
               pend_in = 1'b1;
               eidx_in = rd_idx;
               av_in   = ask_v_ff[rd_idx];
               bv_in   = bid_v_ff[rd_idx];
               cnt_in  = cnt_ff + 1'b1;
               if (state_ff == ST_SCAN && !free_ff) begin
                  if ((cmd_ff.side == SIDE_ASK) ? !ask_v_ff[rd_idx] : !bid_v_ff[rd_idx]) begin
                     free_in = 1'b1;
                     fidx_in = rd_idx;
                  end
               end
            end else if (state_ff == ST_SCAN) begin
               state_in = ST_APPLY;
            end else begin
               state_in = ST_EMIT;
               r_in     = '0;
               eside_in = SIDE_ASK;
            end
         end
         ST_APPLY: begin
            cnt_in   = '0;
            state_in = ST_RANK;
            if (cmd_ff.op == OP_NEW) begin
               if (match_ff) begin
                  wr_data = {cmd_ff.price, sum[QTY_BITS] ? {QTY_BITS{1'b1}} : sum[QTY_BITS-1:0]};
                  ask_wr_en = (cmd_ff.side == SIDE_ASK);
                  bid_wr_en = (cmd_ff.side == SIDE_BID);
               end else if (free_ff) begin
                  wr_idx = fidx_ff;
                  ask_wr_en = (cmd_ff.side == SIDE_ASK);
                  bid_wr_en = (cmd_ff.side == SIDE_BID);
                  if (cmd_ff.side == SIDE_ASK) begin
                     ask_v_in[fidx_ff] = 1'b1;
                  end else begin
                     bid_v_in[fidx_ff] = 1'b1;
                  end
               end else begin
                  status_in = STATUS_FULL;
               end
            end else if (match_ff) begin
               if (cmd_ff.qty >= mqty_ff) begin
                  if (cmd_ff.side == SIDE_ASK) begin
                     ask_v_in[midx_ff] = 1'b0;
                  end else begin
                     bid_v_in[midx_ff] = 1'b0;
                  end
               end else begin
                  wr_data   = {cmd_ff.price, mqty_ff - cmd_ff.qty};
                  ask_wr_en = (cmd_ff.side == SIDE_ASK);
                  bid_wr_en = (cmd_ff.side == SIDE_BID);
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (r_ff == last_rank) begin
                  r_in = '0;
                  if (eside_ff == SIDE_ASK) begin
                     eside_in = SIDE_BID;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp.status              = status_ff;
      rsp.report_side         = eside_ff;
      rsp.rank                = r_ff;
      rsp.level_valid         = (eside_ff == SIDE_ASK) ? al_ff[r_ff] : bl_ff[r_ff];
      rsp.level_price         = '0;
      rsp.level_quantity      = '0;
      if (rsp.level_valid) begin
         rsp.level_price    = (eside_ff == SIDE_ASK) ? ap_ff[r_ff] : bp_ff[r_ff];
         rsp.level_quantity = (eside_ff == SIDE_ASK) ? aq_ff[r_ff] : bq_ff[r_ff];
      end
      rsp.last_trade_price    = trp_ff;
      rsp.last_trade_quantity = trq_ff;
      rsp.last_item           = (eside_ff == SIDE_BID) && (r_ff == last_rank);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         ask_v_ff <= '0;
         bid_v_ff <= '0;
         trp_ff   <= '0;
         trq_ff   <= '0;
         al_ff    <= '0;
         bl_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         ask_v_ff <= ask_v_in;
         bid_v_ff <= bid_v_in;
         trp_ff   <= trp_in;
         trq_ff   <= trq_in;
         al_ff    <= al_in;
         bl_ff    <= bl_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      eidx_ff   <= eidx_in;
      av_ff     <= av_in;
      bv_ff     <= bv_in;
      cmd_ff    <= cmd_in;
      match_ff  <= match_in;
      midx_ff   <= midx_in;
      mqty_ff   <= mqty_in;
      free_ff   <= free_in;
      fidx_ff   <= fidx_in;
      status_ff <= status_in;
      r_ff      <= r_in;
      eside_ff  <= eside_in;
      for (int k = 0; k < TOP_LEVELS; k++) begin
         ap_ff[k] <= ap_in[k];
         aq_ff[k] <= aq_in[k];
         bp_ff[k] <= bp_in[k];
         bq_ff[k] <= bq_in[k];
      end
   end
endmodule
`default_nettype wire

/* sv/price_level_order_book_core.sv */
// Price-level order book with a top-of-book report.
// Input channel (req_*): push one update (side, action, price, quantity) while
// req_full is low; a two-beat queue holds updates ahead of the book engine.
// Result channel (rsp_*): while rsp_empty is low the oldest report beat is on
// the rsp_ ports; rsp_pop takes it. Each update gives depth ask beats (best,
// i.e. lowest, first) then depth bid beats (highest first); rsp_last_item
// marks the final beat. depth is csr_wr_data as last written, clamped to 1..5.
// Flow: a new, cancel or trade scans the 64-entry side memory once to find
// the level and the first free entry, writes it, then scans both side
// memories together to rank the best levels, then sends 2*depth beats, one
// per cycle while the result queue is not full. An unused action skips the
// first scan and the write. The single read port of each side memory, walked
// one entry per cycle, sets the length of each scan.
// A stalled receiver fills the two-beat result queue and halts the engine;
// the input queue keeps accepting until it too is full.
// Reset empties both queues, clears every level and the last trade, and sets
// the depth to 5. Write csr only while no update is in flight.
`timescale 1ns / 1ps
`default_nettype none
module price_level_order_book_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_side,
   input  logic [plob_pkg::ACTION_BITS-1:0] req_action,
   input  logic [plob_pkg::PRICE_BITS-1:0]  req_price,
   input  logic [plob_pkg::QTY_BITS-1:0]    req_quantity,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_status,
   output logic                             rsp_report_side,
   output logic [plob_pkg::RANK_BITS-1:0]   rsp_rank,
   output logic                             rsp_level_valid,
   output logic [plob_pkg::PRICE_BITS-1:0]  rsp_level_price,
   output logic [plob_pkg::QTY_BITS-1:0]    rsp_level_quantity,
   output logic [plob_pkg::PRICE_BITS-1:0]  rsp_last_trade_price,
   output logic [plob_pkg::QTY_BITS-1:0]    rsp_last_trade_quantity,
   output logic                             rsp_last_item,
   input  logic                             csr_wr_en,
   input  logic [plob_pkg::DEPTH_BITS-1:0]  csr_wr_data
);
   import plob_pkg::*;

   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  cmd_valid, cmd_pop, eng_push, eng_full;
   cmd_type               cmd;
   rsp_type               eng_rsp, out_rsp;

   assign depth_in = csr_wr_en ? csr_wr_data : depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else begin
         depth_ff <= depth_in;
      end
   end

   plob_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_side     (req_side),
      .req_action   (req_action),
      .req_price    (req_price),
      .req_quantity (req_quantity),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   plob_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .depth     (depth_ff),
      .rsp_push  (eng_push),
      .rsp       (eng_rsp),
      .rsp_full  (eng_full)
   );

   plob_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (eng_push),
      .din   (eng_rsp),
      .full  (eng_full),
      .empty (rsp_empty),
      .dout  (out_rsp),
      .pop   (rsp_pop)
   );

   assign rsp_status              = out_rsp.status;
   assign rsp_report_side         = out_rsp.report_side;
   assign rsp_rank                = out_rsp.rank;
   assign rsp_level_valid         = out_rsp.level_valid;
   assign rsp_level_price         = out_rsp.level_price;
   assign rsp_level_quantity      = out_rsp.level_quantity;
   assign rsp_last_trade_price    = out_rsp.last_trade_price;
   assign rsp_last_trade_quantity = out_rsp.last_trade_quantity;
   assign rsp_last_item           = out_rsp.last_item;
endmodule
`default_nettype wire

/* sv/plob_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module plob_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_empty,
   input wire                            rsp_pop,
   input wire                            rsp_report_side,
   input wire [plob_pkg::RANK_BITS-1:0]  rsp_rank,
   input wire                            rsp_level_valid,
   input wire [plob_pkg::PRICE_BITS-1:0] rsp_level_price,
   input wire [plob_pkg::QTY_BITS-1:0]   rsp_level_quantity,
   input wire                            rsp_last_item
);
   import plob_pkg::*;

   // a waiting beat holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_level_price)))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_level_valid) |->
         (rsp_level_price == '0 && rsp_level_quantity == '0))
      else $error("absent level carries nonzero data");

   // the report ends on the bid side
   a_last_bid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_item) |-> (rsp_report_side == SIDE_BID))
      else $error("last beat not on bid side");

   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_rank < RANK_BITS'(TOP_LEVELS)))
      else $error("rank beyond reported depth");
endmodule

bind price_level_order_book_core plob_checker u_plob_checker (.*);
`default_nettype wire
